// ===== rtl/core/wvs_pkg.sv =====
`default_nettype none
package wvs_pkg;

  localparam int COORD_W = 32;
  localparam int LT_W    = 20;

  // site kind codes as they appear in the patterns and on site_code
  localparam logic [2:0] K_END = 3'd0;
  localparam logic [2:0] K_O   = 3'd1;
  localparam logic [2:0] K_H   = 3'd2;
  localparam logic [2:0] K_M   = 3'd3;
  localparam logic [2:0] K_L   = 3'd4;
  localparam logic [2:0] K_X   = 3'd5;

  // rows of the site store
  localparam logic [2:0] SITE_O    = 3'd0;
  localparam logic [2:0] SITE_H1   = 3'd1;
  localparam logic [2:0] SITE_H2   = 3'd2;
  localparam logic [2:0] SITE_M    = 3'd3;
  localparam logic [2:0] SITE_L1   = 3'd4;
  localparam logic [2:0] SITE_L2   = 3'd5;
  localparam logic [2:0] SITE_X    = 3'd6;
  localparam logic [2:0] SITE_NONE = 3'd7;

  // kind counter slots
  localparam logic [2:0] KC_O    = 3'd0;
  localparam logic [2:0] KC_H    = 3'd1;
  localparam logic [2:0] KC_M    = 3'd2;
  localparam logic [2:0] KC_L    = 3'd3;
  localparam logic [2:0] KC_X    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_IN_PATTERN  = 3'd0;
  localparam logic [2:0] REG_OUT_PATTERN = 3'd1;
  localparam logic [2:0] REG_M_WEIGHT_O  = 3'd2;
  localparam logic [2:0] REG_LP_SIN      = 3'd3;
  localparam logic [2:0] REG_LP_COS      = 3'd4;
  localparam logic [2:0] REG_COORD_SCALE = 3'd5;
  localparam logic [2:0] REG_COORD_SHIFT = 3'd6;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_COUNT = 2'd1;
  localparam logic [1:0] ERR_NO_X  = 2'd2;

  // vector in work for the lone-pair unit
  localparam logic [1:0] VP_H1 = 2'd0;
  localparam logic [1:0] VP_H2 = 2'd1;
  localparam logic [1:0] VP_P  = 2'd2;
  localparam logic [1:0] VP_A  = 2'd3;

  // datapath commands
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_ACCEPT     = 5'd1;
  localparam logic [4:0] OP_LOAD_MUL   = 5'd2;
  localparam logic [4:0] OP_LOAD_WR    = 5'd3;
  localparam logic [4:0] OP_M_MUL      = 5'd4;
  localparam logic [4:0] OP_M_WR       = 5'd5;
  localparam logic [4:0] OP_V_LOAD     = 5'd6;
  localparam logic [4:0] OP_NORM_STEP  = 5'd7;
  localparam logic [4:0] OP_SAVE_N1    = 5'd8;
  localparam logic [4:0] OP_SAVE_N2    = 5'd9;
  localparam logic [4:0] OP_XMUL1      = 5'd10;
  localparam logic [4:0] OP_XMUL2      = 5'd11;
  localparam logic [4:0] OP_XWR        = 5'd12;
  localparam logic [4:0] OP_SQ_MUL     = 5'd13;
  localparam logic [4:0] OP_SQ_ACC     = 5'd14;
  localparam logic [4:0] OP_SQRT_START = 5'd15;
  localparam logic [4:0] OP_SQRT_STEP  = 5'd16;
  localparam logic [4:0] OP_K_MUL      = 5'd17;
  localparam logic [4:0] OP_DIV_START  = 5'd18;
  localparam logic [4:0] OP_DIV_STEP   = 5'd19;
  localparam logic [4:0] OP_DIV_WR     = 5'd20;
  localparam logic [4:0] OP_ZERO_WR    = 5'd21;
  localparam logic [4:0] OP_L_WR       = 5'd22;
  localparam logic [4:0] OP_EMIT       = 5'd23;
  localparam logic [4:0] OP_EMIT_ERR   = 5'd24;
  localparam logic [4:0] OP_MOL_CLR    = 5'd25;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] ax;
    logic [1:0] vph;
    logic [2:0] slot;
  } cmd_t;

  typedef struct packed {
    logic mol_end;
    logic cnt_err;
    logic m_given;
    logic l_given;
    logic norm_ok;
    logic vec_zero;
    logic sqrt_done;
    logic div_done;
    logic emit_none;
    logic emit_last;
  } stat_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [2:0] pat_code(input logic [23:0] pat, input logic [2:0] idx);
    logic [4:0] base;
    base = 5'(idx) * 5'd3;
    return pat[base +: 3];
  endfunction

  // leading nonzero slots of a pattern
  function automatic logic [3:0] pat_len(input logic [23:0] pat);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (run && pat[3*i +: 3] != K_END) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic [16:0] q16_clamp(input logic [16:0] v);
    return (v > 17'd65536) ? 17'd65536 : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/water_virtual_site_builder.sv =====
`default_nettype none
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: pos_x, pos_y, pos_z
// m_axis    out  tvalid/tready, tlast    tdata: out_x, out_y, out_z; tlast: last_site;
//                                        tuser: site_code, error_code
// cfg       in   cfg_we                  cfg_addr: register index, cfg_data: value
//
// A site that does not end the molecule passes through accept, three axes of
// shift-and-scale through the shared multiplier, and an end check. The closing site
// adds the build phase: M, and for the lone pairs the one-bit normalizing shifter,
// the 32-step square root and the 48-step divider (three divisions per vector).
// Results then leave one per cycle while m_axis is ready.
// Reset is synchronous and clears control state; no clearing pass is needed.
// A stalled m_axis holds the result register; s_axis is taken again once idle.
module water_virtual_site_builder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
  output logic         m_axis_tlast,
  output logic [4:0]   m_axis_tuser,   // site_code, error_code
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);
  import wvs_pkg::*;

  cmd_t               cmd;
  stat_t              st;
  logic [2:0]         site_code;
  logic [1:0]         error_code;
  logic signed [31:0] out_x, out_y, out_z;

  wvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  wvs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .pos_x      ($signed(s_axis_tdata[31:0])),
    .pos_y      ($signed(s_axis_tdata[63:32])),
    .pos_z      ($signed(s_axis_tdata[95:64])),
    .cmd        (cmd),
    .st         (st),
    .site_code  (site_code),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .last_site  (m_axis_tlast),
    .error_code (error_code)
  );

  assign m_axis_tdata = {out_z, out_y, out_x};
  assign m_axis_tuser = {error_code, site_code};

endmodule
`default_nettype wire

// ===== rtl/core/wvs_ctrl.sv =====
`default_nettype none
module wvs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  wvs_pkg::stat_t st,
  output wvs_pkg::cmd_t  cmd
);
  import wvs_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_LMUL  = 5'd1;
  localparam logic [4:0] ST_LWR   = 5'd2;
  localparam logic [4:0] ST_LCHK  = 5'd3;
  localparam logic [4:0] ST_FIN   = 5'd4;
  localparam logic [4:0] ST_MMUL  = 5'd5;
  localparam logic [4:0] ST_MWR   = 5'd6;
  localparam logic [4:0] ST_LSEL  = 5'd7;
  localparam logic [4:0] ST_VLOAD = 5'd8;
  localparam logic [4:0] ST_NORM  = 5'd9;
  localparam logic [4:0] ST_XM1   = 5'd10;
  localparam logic [4:0] ST_XM2   = 5'd11;
  localparam logic [4:0] ST_XWR   = 5'd12;
  localparam logic [4:0] ST_US    = 5'd13;
  localparam logic [4:0] ST_SQM   = 5'd14;
  localparam logic [4:0] ST_SQA   = 5'd15;
  localparam logic [4:0] ST_SQ0   = 5'd16;
  localparam logic [4:0] ST_SQRT  = 5'd17;
  localparam logic [4:0] ST_KMUL  = 5'd18;
  localparam logic [4:0] ST_DIV0  = 5'd19;
  localparam logic [4:0] ST_DIV   = 5'd20;
  localparam logic [4:0] ST_DIVWR = 5'd21;
  localparam logic [4:0] ST_ZWR   = 5'd22;
  localparam logic [4:0] ST_LWRT  = 5'd23;
  localparam logic [4:0] ST_EMIT  = 5'd24;
  localparam logic [4:0] ST_ERR   = 5'd25;
  localparam logic [4:0] ST_CLR   = 5'd26;

  logic [4:0] state, state_next;
  logic [1:0] ax, ax_next;
  logic [1:0] vph, vph_next;
  logic [2:0] slot, slot_next;
  logic       out_free;
  logic       emit;

  assign out_free = !out_valid || out_ready;
  assign emit     = (cmd.op == OP_EMIT) || (cmd.op == OP_EMIT_ERR);

  always_comb begin
    state_next = state;
    ax_next    = ax;
    vph_next   = vph;
    slot_next  = slot;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.ax     = ax;
    cmd.vph    = vph;
    cmd.slot   = slot;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          ax_next    = 2'd0;
          state_next = ST_LMUL;
        end
      end
      ST_LMUL: begin
        cmd.op     = OP_LOAD_MUL;
        state_next = ST_LWR;
      end
      ST_LWR: begin
        cmd.op = OP_LOAD_WR;
        if (ax == 2'd2) begin
          state_next = ST_LCHK;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = ST_LMUL;
        end
      end
      ST_LCHK: begin
        state_next = st.mol_end ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        ax_next = 2'd0;
        if (st.cnt_err) begin
          state_next = ST_ERR;
        end else if (!st.m_given) begin
          state_next = ST_MMUL;
        end else begin
          state_next = ST_LSEL;
        end
      end
      ST_MMUL: begin
        cmd.op     = OP_M_MUL;
        state_next = ST_MWR;
      end
      ST_MWR: begin
        cmd.op = OP_M_WR;
        if (ax == 2'd2) begin
          state_next = ST_LSEL;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = ST_MMUL;
        end
      end
      ST_LSEL: begin
        slot_next = 3'd0;
        ax_next   = 2'd0;
        if (!st.l_given) begin
          vph_next   = VP_H1;
          state_next = ST_VLOAD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_VLOAD: begin
        cmd.op     = OP_V_LOAD;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (st.norm_ok) begin
          ax_next = 2'd0;
          case (vph)
            VP_H1: begin
              cmd.op     = OP_SAVE_N1;
              vph_next   = VP_H2;
              state_next = ST_VLOAD;
            end
            VP_H2: begin
              cmd.op     = OP_SAVE_N2;
              state_next = ST_XM1;
            end
            default: state_next = ST_US;
          endcase
        end else begin
          cmd.op = OP_NORM_STEP;
        end
      end
      ST_XM1: begin
        cmd.op     = OP_XMUL1;
        state_next = ST_XM2;
      end
      ST_XM2: begin
        cmd.op     = OP_XMUL2;
        state_next = ST_XWR;
      end
      ST_XWR: begin
        cmd.op = OP_XWR;
        if (ax == 2'd2) begin
          ax_next    = 2'd0;
          vph_next   = VP_P;
          state_next = ST_NORM;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = ST_XM1;
        end
      end
      ST_US: begin
        ax_next    = 2'd0;
        state_next = st.vec_zero ? ST_ZWR : ST_SQM;
      end
      ST_SQM: begin
        cmd.op     = OP_SQ_MUL;
        state_next = ST_SQA;
      end
      ST_SQA: begin
        cmd.op = OP_SQ_ACC;
        if (ax == 2'd2) begin
          state_next = ST_SQ0;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = ST_SQM;
        end
      end
      ST_SQ0: begin
        cmd.op     = OP_SQRT_START;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (st.sqrt_done) begin
          ax_next    = 2'd0;
          state_next = ST_KMUL;
        end else begin
          cmd.op = OP_SQRT_STEP;
        end
      end
      ST_KMUL: begin
        cmd.op     = OP_K_MUL;
        state_next = ST_DIV0;
      end
      ST_DIV0: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_done) begin
          state_next = ST_DIVWR;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      ST_DIVWR: begin
        cmd.op = OP_DIV_WR;
        if (ax != 2'd2) begin
          ax_next    = ax + 2'd1;
          state_next = ST_KMUL;
        end else if (vph == VP_P) begin
          vph_next   = VP_A;
          state_next = ST_VLOAD;
        end else begin
          ax_next    = 2'd0;
          state_next = ST_LWRT;
        end
      end
      ST_ZWR: begin
        cmd.op = OP_ZERO_WR;
        ax_next = 2'd0;
        if (vph == VP_P) begin
          vph_next   = VP_A;
          state_next = ST_VLOAD;
        end else begin
          state_next = ST_LWRT;
        end
      end
      ST_LWRT: begin
        cmd.op = OP_L_WR;
        if (ax == 2'd2) begin
          slot_next  = 3'd0;
          state_next = ST_EMIT;
        end else begin
          ax_next = ax + 2'd1;
        end
      end
      ST_EMIT: begin
        if (st.emit_none) begin
          state_next = ST_CLR;
        end else if (out_free) begin
          cmd.op = OP_EMIT;
          if (st.emit_last) begin
            state_next = ST_CLR;
          end else begin
            slot_next = slot + 3'd1;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          cmd.op     = OP_EMIT_ERR;
          state_next = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.op     = OP_MOL_CLR;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ax        <= 2'd0;
      vph       <= VP_H1;
      slot      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
      vph   <= vph_next;
      slot  <= slot_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wvs_dp.sv =====
`default_nettype none
module wvs_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_data,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  wvs_pkg::cmd_t         cmd,
  output wvs_pkg::stat_t        st,
  output logic [2:0]            site_code,
  output logic signed [31:0]    out_x,
  output logic signed [31:0]    out_y,
  output logic signed [31:0]    out_z,
  output logic                  last_site,
  output logic [1:0]            error_code
);
  import wvs_pkg::*;

  // configuration
  logic [23:0]        in_pattern, out_pattern;
  logic [16:0]        m_weight_o, lp_sin, lp_cos;
  logic [23:0]        coord_scale;
  logic signed [31:0] coord_shift;

  // molecule bookkeeping
  logic [2:0]         site_index;
  logic [3:0]         kind_counts [5];
  logic [2:0]         slot_sel;
  logic               mol_end;
  logic               oh_seen, ol_seen;

  logic signed [31:0] pos [3];
  logic signed [31:0] site_store [7][3];

  // arithmetic registers
  logic signed [63:0]     vec [3];
  logic signed [30:0]     n1 [3];
  logic signed [30:0]     n2 [3];
  logic signed [63:0]     preg, acc;
  logic [62:0]            sq_x, sq_res, sq_bit;
  logic [47:0]            dvd;
  logic [31:0]            rem;
  logic [5:0]             dcnt;
  logic                   dneg;
  logic signed [LT_W-1:0] sp [3];
  logic signed [LT_W-1:0] ca [3];

  // accept decode
  logic [2:0] in_code, kidx, new_slot, idx_inc;
  logic [3:0] kcnt_new, len;

  always_comb begin
    in_code = pat_code(in_pattern, site_index);
    case (in_code)
      K_END:   kidx = 3'd7;
      K_O:     kidx = KC_O;
      K_H:     kidx = KC_H;
      K_M:     kidx = KC_M;
      K_L:     kidx = KC_L;
      default: kidx = KC_X;
    endcase
    kcnt_new = 4'd0;
    if (kidx != 3'd7) begin
      kcnt_new = (kind_counts[kidx] == 4'd15) ? 4'd15 : kind_counts[kidx] + 4'd1;
    end
    case (in_code)
      K_END:   new_slot = SITE_NONE;
      K_O:     new_slot = SITE_O;
      K_H:     new_slot = (kcnt_new == 4'd1) ? SITE_H1 : SITE_H2;
      K_M:     new_slot = SITE_M;
      K_L:     new_slot = (kcnt_new == 4'd1) ? SITE_L1 : SITE_L2;
      default: new_slot = SITE_X;
    endcase
    idx_inc = site_index + 3'd1;
    len     = pat_len(in_pattern);
  end

  // axis pair for the cross product
  logic [1:0] xa, xb;
  always_comb begin
    case (cmd.ax)
      2'd0:    begin xa = 2'd1; xb = 2'd2; end
      2'd1:    begin xa = 2'd2; xb = 2'd0; end
      default: begin xa = 2'd0; xb = 2'd1; end
    endcase
  end

  // operands at the working axis
  logic signed [31:0] o_ax;
  logic signed [33:0] dsum [3];
  logic [16:0]        m_k, lp_k;

  always_comb begin
    o_ax  = site_store[SITE_O][cmd.ax];
    for (int c = 0; c < 3; c++) begin
      dsum[c] = (34'(site_store[SITE_H1][c]) - 34'(site_store[SITE_O][c]))
              + (34'(site_store[SITE_H2][c]) - 34'(site_store[SITE_O][c]));
    end
    m_k  = 17'd65536 - q16_clamp(m_weight_o);
    lp_k = (cmd.vph == VP_P) ? q16_clamp(lp_sin) : q16_clamp(lp_cos);
  end

  // shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic               mul_en;

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_LOAD_MUL: begin
        ma = 34'(pos[cmd.ax]) + 34'(coord_shift);
        mb = $signed({10'd0, coord_scale});
      end
      OP_M_MUL: begin
        ma = dsum[cmd.ax];
        mb = $signed({17'd0, m_k});
      end
      OP_XMUL1: begin
        ma = 34'(n1[xa]);
        mb = 34'(n2[xb]);
      end
      OP_XMUL2: begin
        ma = 34'(n1[xb]);
        mb = 34'(n2[xa]);
      end
      OP_SQ_MUL: begin
        ma = vec[cmd.ax][33:0];
        mb = vec[cmd.ax][33:0];
      end
      OP_K_MUL: begin
        ma = vec[cmd.ax][33:0];
        mb = $signed({17'd0, lp_k});
      end
      default: mul_en = 1'b0;
    endcase
    prod = ma * mb;
  end

  // normalization flags
  logic [63:0] vabs [3];
  logic        v_big, v_small, v_zero;

  always_comb begin
    v_big   = 1'b0;
    v_small = 1'b1;
    v_zero  = 1'b1;
    for (int c = 0; c < 3; c++) begin
      vabs[c] = vec[c][63] ? 64'(-vec[c]) : 64'(vec[c]);
      if (|vabs[c][62:30]) v_big = 1'b1;
      if (|vabs[c][62:29]) v_small = 1'b0;
      if (vec[c] != 64'sd0) v_zero = 1'b0;
    end
  end

  // iterative units
  logic [62:0] sq_try;
  logic [32:0] rem2;
  logic        div_ge;
  logic [31:0] nrm;
  logic [63:0] pmag;
  logic [18:0] quo;

  always_comb begin
    sq_try = sq_res + sq_bit;
    nrm    = sq_res[31:0];
    rem2   = {rem, dvd[47]};
    div_ge = rem2 >= {1'b0, nrm};
    pmag   = preg[63] ? 64'(-preg) : 64'(preg);
    quo    = dvd[18:0];
  end

  // emission
  logic [2:0] e_code, e_next, e_row;
  logic       e_miss;

  always_comb begin
    e_code = pat_code(out_pattern, cmd.slot);
    e_next = pat_code(out_pattern, cmd.slot + 3'd1);
    e_miss = (e_code >= K_X) && (kind_counts[KC_X] == 4'd0);
    case (e_code)
      K_O:     e_row = SITE_O;
      K_H:     e_row = oh_seen ? SITE_H2 : SITE_H1;
      K_M:     e_row = SITE_M;
      K_L:     e_row = ol_seen ? SITE_L2 : SITE_L1;
      default: e_row = SITE_X;
    endcase
  end

  always_comb begin
    st.mol_end   = mol_end;
    st.cnt_err   = (kind_counts[KC_O] != 4'd1) || (kind_counts[KC_H] != 4'd2);
    st.m_given   = kind_counts[KC_M] != 4'd0;
    st.l_given   = kind_counts[KC_L] == 4'd2;
    st.norm_ok   = v_zero || (!v_big && !v_small);
    st.vec_zero  = v_zero;
    st.sqrt_done = sq_bit == 63'd0;
    st.div_done  = dcnt == 6'd0;
    st.emit_none = e_code == K_END;
    st.emit_last = (cmd.slot == 3'd7) || (e_next == K_END) || e_miss;
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pattern  <= 24'd145;
      out_pattern <= 24'd1681;
      m_weight_o  <= 17'd48243;
      lp_sin      <= 17'd54010;
      lp_cos      <= 17'd37120;
      coord_scale <= 24'd65536;
      coord_shift <= 32'sd0;
      site_index  <= 3'd0;
      mol_end     <= 1'b0;
      oh_seen     <= 1'b0;
      ol_seen     <= 1'b0;
      for (int k = 0; k < 5; k++) kind_counts[k] <= 4'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_IN_PATTERN:  in_pattern  <= cfg_data[23:0];
          REG_OUT_PATTERN: out_pattern <= cfg_data[23:0];
          REG_M_WEIGHT_O:  m_weight_o  <= cfg_data[16:0];
          REG_LP_SIN:      lp_sin      <= cfg_data[16:0];
          REG_LP_COS:      lp_cos      <= cfg_data[16:0];
          REG_COORD_SCALE: coord_scale <= cfg_data[23:0];
          REG_COORD_SHIFT: coord_shift <= $signed(cfg_data);
          default: ;
        endcase
      end
      case (cmd.op)
        OP_ACCEPT: begin
          if (kidx != 3'd7) kind_counts[kidx] <= kcnt_new;
          site_index <= idx_inc;
          mol_end    <= (idx_inc == 3'd0) || ({1'b0, idx_inc} >= len);
        end
        OP_EMIT: begin
          if (e_code == K_H) oh_seen <= 1'b1;
          if (e_code == K_L) ol_seen <= 1'b1;
        end
        OP_MOL_CLR: begin
          site_index <= 3'd0;
          oh_seen    <= 1'b0;
          ol_seen    <= 1'b0;
          for (int k = 0; k < 5; k++) kind_counts[k] <= 4'd0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mul_en) preg <= prod[63:0];
    case (cmd.op)
      OP_ACCEPT: begin
        pos[0]   <= pos_x;
        pos[1]   <= pos_y;
        pos[2]   <= pos_z;
        slot_sel <= new_slot;
      end
      OP_LOAD_WR: begin
        if (slot_sel != SITE_NONE) begin
          site_store[slot_sel][cmd.ax] <= sat32((preg + 64'sd32768) >>> 16);
        end
      end
      OP_M_WR: begin
        site_store[SITE_M][cmd.ax] <= sat32(64'(o_ax) + ((preg + 64'sd65536) >>> 17));
      end
      OP_V_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          case (cmd.vph)
            VP_H1:   vec[c] <= 64'(site_store[SITE_H1][c]) - 64'(site_store[SITE_O][c]);
            VP_H2:   vec[c] <= 64'(site_store[SITE_H2][c]) - 64'(site_store[SITE_O][c]);
            default: vec[c] <= 64'(dsum[c]);
          endcase
        end
      end
      OP_NORM_STEP: begin
        // scale down truncating toward zero, or up by one bit
        for (int c = 0; c < 3; c++) begin
          if (v_big) begin
            vec[c] <= (vec[c] + $signed({63'd0, vec[c][63]})) >>> 1;
          end else begin
            vec[c] <= vec[c] <<< 1;
          end
        end
      end
      OP_SAVE_N1: for (int c = 0; c < 3; c++) n1[c] <= vec[c][30:0];
      OP_SAVE_N2: for (int c = 0; c < 3; c++) n2[c] <= vec[c][30:0];
      OP_XMUL2:   acc <= preg;
      OP_XWR:     vec[cmd.ax] <= acc - preg;
      OP_SQ_ACC:  acc <= ((cmd.ax == 2'd0) ? 64'sd0 : acc) + preg;
      OP_SQRT_START: begin
        sq_x   <= acc[62:0];
        sq_res <= 63'd0;
        sq_bit <= 63'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sq_x >= sq_try) begin
          sq_x   <= sq_x - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_DIV_START: begin
        dneg <= preg[63];
        dvd  <= pmag[47:0] + {17'd0, nrm[31:1]};
        rem  <= 32'd0;
        dcnt <= 6'd48;
      end
      OP_DIV_STEP: begin
        rem  <= div_ge ? 32'(rem2 - {1'b0, nrm}) : rem2[31:0];
        dvd  <= {dvd[46:0], div_ge};
        dcnt <= dcnt - 6'd1;
      end
      OP_DIV_WR: begin
        if (cmd.vph == VP_P) begin
          sp[cmd.ax] <= dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end else begin
          ca[cmd.ax] <= dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
      end
      OP_ZERO_WR: begin
        for (int c = 0; c < 3; c++) begin
          if (cmd.vph == VP_P) begin
            sp[c] <= '0;
          end else begin
            ca[c] <= '0;
          end
        end
      end
      OP_L_WR: begin
        site_store[SITE_L1][cmd.ax] <=
          sat32(64'(o_ax) - 64'(ca[cmd.ax]) + 64'(sp[cmd.ax]));
        site_store[SITE_L2][cmd.ax] <=
          sat32(64'(o_ax) - 64'(ca[cmd.ax]) - 64'(sp[cmd.ax]));
      end
      OP_EMIT: begin
        if (e_miss) begin
          site_code  <= K_END;
          out_x      <= '0;
          out_y      <= '0;
          out_z      <= '0;
          last_site  <= 1'b1;
          error_code <= ERR_NO_X;
        end else begin
          site_code  <= (e_code >= K_X) ? K_X : e_code;
          out_x      <= site_store[e_row][0];
          out_y      <= site_store[e_row][1];
          out_z      <= site_store[e_row][2];
          last_site  <= st.emit_last;
          error_code <= ERR_NONE;
        end
      end
      OP_EMIT_ERR: begin
        site_code  <= K_END;
        out_x      <= '0;
        out_y      <= '0;
        out_z      <= '0;
        last_site  <= 1'b1;
        error_code <= ERR_COUNT;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/wvs_chk.sv =====
`default_nettype none
module wvs_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [4:0]  m_axis_tuser,
  input logic        cfg_we,
  input logic [2:0]  cfg_addr,
  input logic [31:0] cfg_data
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[4:3] != 2'd0 |->
      m_axis_tlast && m_axis_tuser[2:0] == 3'd0 && m_axis_tdata == 96'd0)
    else $error("error result malformed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2:0] != 3'd6 && m_axis_tuser[2:0] != 3'd7
      && m_axis_tuser[4:3] != 2'd3)
    else $error("site or error code out of range");

endmodule

bind water_virtual_site_builder wvs_chk u_chk (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wvs_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    logic [2:0]  code;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
    logic [1:0]  err;
  } site_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [4:0]  m_axis_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_data;

  logic [95:0]  site_feed [$];
  site_result_t expected_sites [$];
  int           fails;
  int           send_idle;
  int           recv_stall;
  int           hold_left;
  logic         in_fire;

  // predictor copy of the configuration and molecule state
  logic [23:0] mdl_in_pat;
  logic [23:0] mdl_out_pat;
  logic [16:0] mdl_weight;
  logic [16:0] mdl_sin;
  logic [16:0] mdl_cos;
  logic [23:0] mdl_scale;
  logic [31:0] mdl_shift;
  int          mdl_index;
  longint      mdl_store [21];
  int          mdl_counts [5];

  water_virtual_site_builder i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint sat32_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned largest_mag(vec3_t v);
    longint unsigned m;
    longint unsigned a;
    m = 0;
    for (int c = 0; c < 3; c++) begin
      a = v[c] < 0 ? -v[c] : v[c];
      if (a > m) m = a;
    end
    return m;
  endfunction

  // bring the largest component into [2^29, 2^30)
  function automatic void normalize_range(inout vec3_t v);
    longint unsigned m;
    int s;
    m = largest_mag(v);
    s = 0;
    if (m == 0) return;
    while ((m >> s) >= (64'd1 << 30)) s++;
    if (s > 0) begin
      for (int c = 0; c < 3; c++) v[c] = v[c] / (64'sd1 << s);
      return;
    end
    while ((m << s) < (64'd1 << 29)) s++;
    for (int c = 0; c < 3; c++) v[c] = v[c] * (64'sd1 << s);
  endfunction

  function automatic void scaled_unit(vec3_t v, longint k, output vec3_t o);
    vec3_t w;
    longint unsigned sq;
    longint n;
    w = v;
    sq = 0;
    normalize_range(w);
    if (largest_mag(w) == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return;
    end
    for (int c = 0; c < 3; c++) sq = sq + longint'(w[c] * w[c]);
    n = floor_sqrt(sq);
    for (int c = 0; c < 3; c++) o[c] = div_round(k * w[c], n);
  endfunction

  function automatic longint clamp_q16(logic [16:0] v);
    return v > 17'd65536 ? 65536 : longint'(v);
  endfunction

  task automatic push_site(logic [2:0] code, int row, logic [1:0] err);
    site_result_t r;
    r.code = code;
    r.x = row < 0 ? 32'd0 : mdl_store[row * 3][31:0];
    r.y = row < 0 ? 32'd0 : mdl_store[row * 3 + 1][31:0];
    r.z = row < 0 ? 32'd0 : mdl_store[row * 3 + 2][31:0];
    r.last = 1'b0;
    r.err = err;
    expected_sites.push_back(r);
  endtask

  task automatic build_molecule();
    longint k, d, dh, dl, t;
    vec3_t h1, h2, a, p, ca, sp;
    int n, oh, ol;
    logic [2:0] code;
    n = 0; oh = 0; ol = 0;
    if (mdl_counts[KC_O] != 1 || mdl_counts[KC_H] != 2) begin
      push_site(K_END, -1, ERR_COUNT);
      expected_sites[$].last = 1'b1;
      return;
    end
    if (mdl_counts[KC_M] == 0) begin
      k = 65536 - clamp_q16(mdl_weight);
      for (int c = 0; c < 3; c++) begin
        d = (mdl_store[SITE_H1 * 3 + c] - mdl_store[c]) + (mdl_store[SITE_H2 * 3 + c] - mdl_store[c]);
        dh = d >>> 17;
        dl = d - dh * 131072;
        t = dh * k + ((dl * k + 65536) >>> 17);
        mdl_store[SITE_M * 3 + c] = sat32_l(mdl_store[c] + t);
      end
    end
    if (mdl_counts[KC_L] != 2) begin
      for (int c = 0; c < 3; c++) begin
        h1[c] = mdl_store[SITE_H1 * 3 + c] - mdl_store[c];
        h2[c] = mdl_store[SITE_H2 * 3 + c] - mdl_store[c];
        a[c] = h1[c] + h2[c];
      end
      normalize_range(h1);
      normalize_range(h2);
      p[0] = h1[1] * h2[2] - h1[2] * h2[1];
      p[1] = h1[2] * h2[0] - h1[0] * h2[2];
      p[2] = h1[0] * h2[1] - h1[1] * h2[0];
      scaled_unit(a, clamp_q16(mdl_cos), ca);
      scaled_unit(p, clamp_q16(mdl_sin), sp);
      for (int c = 0; c < 3; c++) begin
        mdl_store[SITE_L1 * 3 + c] = sat32_l(mdl_store[c] - ca[c] + sp[c]);
        mdl_store[SITE_L2 * 3 + c] = sat32_l(mdl_store[c] - ca[c] - sp[c]);
      end
    end
    for (int slot = 0; slot < 8; slot++) begin
      code = mdl_out_pat[3 * slot +: 3];
      if (code == K_END) break;
      n++;
      if (code == K_O) begin
        push_site(K_O, SITE_O, ERR_NONE);
      end else if (code == K_H) begin
        oh++;
        push_site(K_H, oh == 1 ? SITE_H1 : SITE_H2, ERR_NONE);
      end else if (code == K_M) begin
        push_site(K_M, SITE_M, ERR_NONE);
      end else if (code == K_L) begin
        ol++;
        push_site(K_L, ol == 1 ? SITE_L1 : SITE_L2, ERR_NONE);
      end else if (mdl_counts[KC_X] != 0) begin
        push_site(K_X, SITE_X, ERR_NONE);
      end else begin
        push_site(K_END, -1, ERR_NO_X);
        break;
      end
    end
    if (n > 0) expected_sites[$].last = 1'b1;
  endtask

  // queue one site for the block and predict what it causes
  task automatic send_site(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic [31:0] pos [3];
    longint v;
    longint r [3];
    int len, row;
    logic [2:0] code;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    len = 0;
    while (len < 8 && mdl_in_pat[3 * len +: 3] != K_END) len++;
    for (int c = 0; c < 3; c++) begin
      v = (longint'($signed(pos[c])) + longint'($signed(mdl_shift))) * longint'(mdl_scale);
      r[c] = sat32_l((v + 32768) >>> 16);
    end
    code = mdl_in_pat[3 * mdl_index +: 3];
    row = -1;
    case (code)
      K_END: ;
      K_O: begin mdl_counts[KC_O]++; row = SITE_O; end
      K_H: begin mdl_counts[KC_H]++; row = mdl_counts[KC_H] == 1 ? SITE_H1 : SITE_H2; end
      K_M: begin mdl_counts[KC_M]++; row = SITE_M; end
      K_L: begin mdl_counts[KC_L]++; row = mdl_counts[KC_L] == 1 ? SITE_L1 : SITE_L2; end
      default: begin mdl_counts[KC_X]++; row = SITE_X; end
    endcase
    for (int c = 0; c < 5; c++) if (mdl_counts[c] > 15) mdl_counts[c] = 15;
    if (row >= 0) for (int c = 0; c < 3; c++) mdl_store[row * 3 + c] = r[c];
    site_feed.push_back({pz, py, px});
    mdl_index = (mdl_index + 1) % 8;
    if (mdl_index != 0 && mdl_index < len) return;
    build_molecule();
    mdl_index = 0;
    for (int c = 0; c < 5; c++) mdl_counts[c] = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IN_PATTERN:  mdl_in_pat = val[23:0];
      REG_OUT_PATTERN: mdl_out_pat = val[23:0];
      REG_M_WEIGHT_O:  mdl_weight = val[16:0];
      REG_LP_SIN:      mdl_sin = val[16:0];
      REG_LP_COS:      mdl_cos = val[16:0];
      REG_COORD_SCALE: mdl_scale = val[23:0];
      REG_COORD_SHIFT: mdl_shift = val;
      default: ;
    endcase
  endtask

  // hold until the block has drained and finished any silent molecule
  task automatic wait_drained();
    while (site_feed.size() != 0 || s_axis_tvalid || expected_sites.size() != 0)
      @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'h1FFFF;
      3: return $urandom_range(65536);
      default: return $urandom_range(131071);
    endcase
  endfunction

  function automatic logic [23:0] well_formed_pattern();
    logic [2:0] kinds [$];
    logic [23:0] pat;
    int j;
    logic [2:0] tmp;
    kinds = '{K_O, K_H, K_H};
    if ($urandom_range(2) == 0) kinds.push_back(K_M);
    repeat ($urandom_range(3)) kinds.push_back(K_L);
    if ($urandom_range(2) == 0) kinds.push_back(3'($urandom_range(7, 5)));
    if ($urandom_range(5) == 0) kinds.push_back(3'($urandom_range(2, 1)));
    for (int i = kinds.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = kinds[i]; kinds[i] = kinds[j]; kinds[j] = tmp;
    end
    pat = '0;
    for (int i = 0; i < kinds.size() && i < 8; i++) pat[3 * i +: 3] = kinds[i];
    return pat;
  endfunction

  function automatic logic [23:0] random_out_pattern();
    logic [23:0] pat;
    int n;
    pat = '0;
    n = $urandom_range(8);
    if ($urandom_range(9) == 0) return '0;
    for (int i = 0; i < n; i++) pat[3 * i +: 3] = 3'($urandom_range(7, 1));
    return pat;
  endfunction

  task automatic send_random_molecule_site(logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    if ($urandom_range(3) == 0)
      send_site($urandom, $urandom, $urandom);
    else
      send_site(bx + $urandom_range(262143) - 131072, by + $urandom_range(262143) - 131072,
                bz + $urandom_range(262143) - 131072);
  endtask

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    site_result_t e;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_sites.size() == 0) begin
        $error("result with nothing expected: site_code %0d", m_axis_tuser[2:0]);
        fails++;
      end else begin
        e = expected_sites.pop_front();
        if (m_axis_tuser[2:0] !== e.code) begin
          $error("site_code expected %0d actual %0d", e.code, m_axis_tuser[2:0]); fails++;
        end
        if (m_axis_tdata[31:0] !== e.x) begin
          $error("out_x expected %h actual %h", e.x, m_axis_tdata[31:0]); fails++;
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          $error("out_y expected %h actual %h", e.y, m_axis_tdata[63:32]); fails++;
        end
        if (m_axis_tdata[95:64] !== e.z) begin
          $error("out_z expected %h actual %h", e.z, m_axis_tdata[95:64]); fails++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_site expected %0d actual %0d", e.last, m_axis_tlast); fails++;
        end
        if (m_axis_tuser[4:3] !== e.err) begin
          $error("error_code expected %0d actual %0d", e.err, m_axis_tuser[4:3]); fails++;
        end
      end
    end
  end

  // driver: advance the input stream at the falling edge
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (site_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tdata <= site_feed.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= !rst && $urandom_range(99) >= recv_stall;
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] bx, by, bz;
    int count;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    in_fire = 1'b0;
    fails = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_left = 0;
    mdl_in_pat = 24'd145;
    mdl_out_pat = 24'd1681;
    mdl_weight = 17'd48243;
    mdl_sin = 17'd54010;
    mdl_cos = 17'd37120;
    mdl_scale = 24'd65536;
    mdl_shift = 32'd0;
    mdl_index = 0;
    for (int i = 0; i < 21; i++) mdl_store[i] = 0;
    for (int i = 0; i < 5; i++) mdl_counts[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, plain and degenerate molecules, extreme coordinates
    send_site(0, 0, 0); send_site(62731, 0, 0); send_site(-15710, 60734, 0);
    send_site(32'h7FFFFFFF, 32'h80000000, 0);
    send_site(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_site(0, 32'hFFFFFFFF, 32'h7FFFFFFF);
    send_site(100, 100, 100); send_site(100, 100, 100); send_site(100, 100, 100);
    send_site(0, 0, 0); send_site(65536, 0, 0); send_site(-65536, 0, 0);
    wait_drained();
    // directed: extreme registers, every output kind but O, X and L given on input
    write_reg(REG_IN_PATTERN, {12'd0, K_X, K_L, K_H, K_H, K_O} | 24'(K_L) << 15);
    write_reg(REG_OUT_PATTERN, {3'd7, 3'd6, K_L, K_L, K_L, K_M, K_H, K_H});
    write_reg(REG_M_WEIGHT_O, 32'h1FFFF);
    write_reg(REG_LP_SIN, 32'd65536);
    write_reg(REG_LP_COS, 32'h1FFFF);
    write_reg(REG_COORD_SCALE, 32'hFFFFFF);
    write_reg(REG_COORD_SHIFT, 32'h7FFFFFFF);
    for (int i = 0; i < 6; i++) send_site($urandom, $urandom, $urandom);
    wait_drained();
    // empty input pattern, then missing X requested
    write_reg(REG_IN_PATTERN, 32'd0);
    write_reg(REG_COORD_SHIFT, 32'h80000000);
    write_reg(REG_COORD_SCALE, 32'd0);
    send_site(1, 2, 3); send_site(4, 5, 6);
    wait_drained();
    write_reg(REG_IN_PATTERN, 32'd145);
    write_reg(REG_OUT_PATTERN, {15'd0, K_X, K_M, K_O});
    write_reg(REG_M_WEIGHT_O, 32'd0);
    write_reg(REG_COORD_SCALE, 32'd65536);
    write_reg(REG_COORD_SHIFT, 32'd0);
    send_site(0, 0, 0); send_site(65536, 0, 0); send_site(0, 65536, 0);
    wait_drained();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 76; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 76; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      write_reg(REG_IN_PATTERN, $urandom_range(9) < 8 ? well_formed_pattern()
                : ($urandom_range(1) ? 24'($urandom) : 24'd0));
      write_reg(REG_OUT_PATTERN, random_out_pattern());
      write_reg(REG_M_WEIGHT_O, pick_q16());
      write_reg(REG_LP_SIN, pick_q16());
      write_reg(REG_LP_COS, pick_q16());
      case ($urandom_range(5))
        0: write_reg(REG_COORD_SCALE, 32'hFFFFFF);
        1: write_reg(REG_COORD_SCALE, 32'd0);
        2: write_reg(REG_COORD_SCALE, $urandom_range(24'hFFFFFF));
        default: write_reg(REG_COORD_SCALE, $urandom_range(131072, 32768));
      endcase
      case ($urandom_range(5))
        0: write_reg(REG_COORD_SHIFT, $urandom);
        1: write_reg(REG_COORD_SHIFT, $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000);
        default: write_reg(REG_COORD_SHIFT, $urandom_range(131072) - 65536);
      endcase
      // long receiver hold while the sender keeps offering
      if (ph == 4) hold_left = 1500;
      count = 16 + $urandom_range(6);
      for (int i = 0; i < count; i++) begin
        if (mdl_index == 0) begin
          bx = $urandom_range(1) ? $urandom : $urandom_range(8388607) - 4194304;
          by = $urandom_range(1) ? $urandom : $urandom_range(8388607) - 4194304;
          bz = $urandom_range(1) ? $urandom : $urandom_range(8388607) - 4194304;
        end
        send_random_molecule_site(bx, by, bz);
      end
      wait_drained();
    end

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/wvs_pkg.sv
rtl/core/wvs_ctrl.sv
rtl/core/wvs_dp.sv
rtl/core/water_virtual_site_builder.sv
rtl/core/wvs_chk.sv
test/testbench.sv
